FILE: design/c8x_pkg.sv
// Shared types, opcode codes and constants for the instruction executor.
`timescale 1ns / 1ps
`default_nettype none
package c8x_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int SLW = $clog2(STACK_DEPTH + 1);  // stack level width
  localparam int SAW = $clog2(STACK_DEPTH);      // stack address width

  localparam logic [11:0] PC_RESET = 12'h200;
  localparam logic [15:0] CLS_WORD = 16'h00E0;
  localparam logic [15:0] RET_WORD = 16'h00EE;
  localparam logic [7:0]  KEY_DOWN_CODE = 8'h9E;
  localparam logic [7:0]  KEY_UP_CODE   = 8'hA1;
  localparam logic [7:0]  KEY_MAX  = 8'd15;
  localparam logic [3:0]  FLAG_REG = 4'hF;

  // major opcodes
  localparam logic [3:0] OP_SYS     = 4'h0;
  localparam logic [3:0] OP_JP      = 4'h1;
  localparam logic [3:0] OP_CALL    = 4'h2;
  localparam logic [3:0] OP_SE_IMM  = 4'h3;
  localparam logic [3:0] OP_SNE_IMM = 4'h4;
  localparam logic [3:0] OP_SE_REG  = 4'h5;
  localparam logic [3:0] OP_LD_IMM  = 4'h6;
  localparam logic [3:0] OP_ADD_IMM = 4'h7;
  localparam logic [3:0] OP_ALU     = 4'h8;
  localparam logic [3:0] OP_SNE_REG = 4'h9;
  localparam logic [3:0] OP_LD_I    = 4'hA;
  localparam logic [3:0] OP_JP_V0   = 4'hB;
  localparam logic [3:0] OP_RND     = 4'hC;
  localparam logic [3:0] OP_KEY     = 4'hE;

  // 8xyn sub-operations
  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BAD_KEY   = 2'd3
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [11:0] pc;
    logic        clr;
    logic        rw;
    logic [3:0]  x;
    logic [7:0]  rval;
    logic        fw;
    logic [7:0]  vf;
    logic [11:0] index;
    logic        push;
    logic        pop;
    logic [11:0] ret_pc;
  } exec_res_t;

endpackage
`default_nettype wire

FILE: design/c8x_regfile.sv
// General register file: V0..VF storage with write forwarding and a separate VF flop.
`timescale 1ns / 1ps
`default_nettype none
module c8x_regfile (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       rd_en,
  input  wire logic [3:0] rd_addr_a,
  input  wire logic [3:0] rd_addr_b,
  input  wire logic       wr_en,
  input  wire logic [3:0] wr_addr,
  input  wire logic [7:0] wr_data,
  input  wire logic       vf_en,
  input  wire logic [7:0] vf_data,
  output logic      [7:0] rd_data_a,
  output logic      [7:0] rd_data_b,
  output logic      [7:0] vf
);
  import c8x_pkg::*;

  logic [7:0]  mem [16];
  logic [15:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read at accept; a write landing on the same edge is forwarded
    if (rd_en) begin
      if (wr_en && wr_addr == rd_addr_a) begin
        rd_data_a <= wr_data;
      end else begin
        rd_data_a <= valid[rd_addr_a] ? mem[rd_addr_a] : 8'd0;
      end
      if (wr_en && wr_addr == rd_addr_b) begin
        rd_data_b <= wr_data;
      end else begin
        rd_data_b <= valid[rd_addr_b] ? mem[rd_addr_b] : 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vf    <= 8'd0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (vf_en) begin
        vf <= vf_data;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/c8x_stack.sv
// Return stack: memory, level counter and registered top-of-stack.
`timescale 1ns / 1ps
`default_nettype none
module c8x_stack (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  input  wire logic                    pop,
  input  wire logic [11:0]             push_data,
  output logic      [c8x_pkg::SLW-1:0] level,
  output logic      [11:0]             tos
);
  import c8x_pkg::*;

  logic [11:0]    mem [STACK_DEPTH];
  logic [SLW-1:0] level_next;
  logic [SLW-1:0] rd_ptr;

  always_comb begin
    if (push) begin
      level_next = level + SLW'(1);
    end else if (pop) begin
      level_next = level - SLW'(1);
    end else begin
      level_next = level;
    end
  end

  // top entry after this edge lives at level_next - 1
  assign rd_ptr = level_next - SLW'(1);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[level[SAW-1:0]] <= push_data;
      tos <= push_data;
    end else begin
      tos <= mem[rd_ptr[SAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else begin
      level <= level_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/c8x_exec.sv
// Instruction decode and execute: branch, ALU, flag and stack decisions.
`timescale 1ns / 1ps
`default_nettype none
module c8x_exec (
  input  wire logic [15:0]             word,
  input  wire logic [15:0]             keys,
  input  wire logic [7:0]              rnd,
  input  wire logic [7:0]              rd_a,
  input  wire logic [7:0]              rd_b,
  input  wire logic [7:0]              vf,
  input  wire logic [11:0]             pc,
  input  wire logic [11:0]             index,
  input  wire logic [c8x_pkg::SLW-1:0] level,
  input  wire logic [11:0]             tos,
  output c8x_pkg::exec_res_t           res
);
  import c8x_pkg::*;

  logic [3:0]  op, x, y, n;
  logic [7:0]  kk;
  logic [11:0] nnn;
  logic [7:0]  vx, vy;
  logic [11:0] pc_adv, pc_skip, pc_new, index_new;
  logic [8:0]  sum;
  logic        key_hit;
  status_t     status;
  logic        clr, rw, fw, push, pop;
  logic [7:0]  rval, fval;

  assign op  = word[15:12];
  assign x   = word[11:8];
  assign y   = word[7:4];
  assign n   = word[3:0];
  assign kk  = word[7:0];
  assign nnn = word[11:0];

  // port b carries V0 for Bnnn, so only map VF when it really holds Vy
  assign vx = (x == FLAG_REG) ? vf : rd_a;
  assign vy = (op != OP_JP_V0 && y == FLAG_REG) ? vf : rd_b;

  assign pc_adv  = pc + 12'd2;
  assign pc_skip = pc + 12'd4;
  assign sum     = {1'b0, vx} + {1'b0, vy};
  assign key_hit = keys[vx[3:0]];

  always_comb begin
    status    = ST_OK;
    pc_new    = pc_adv;
    clr       = 1'b0;
    rw        = 1'b0;
    rval      = 8'd0;
    fw        = 1'b0;
    fval      = 8'd0;
    index_new = index;
    push      = 1'b0;
    pop       = 1'b0;
    unique case (op)
      OP_SYS: begin
        if (word == CLS_WORD) begin
          clr = 1'b1;
        end else if (word == RET_WORD) begin
          if (level == '0) begin
            status = ST_UNDERFLOW;
          end else begin
            pop    = 1'b1;
            pc_new = tos;
          end
        end
      end
      OP_JP: pc_new = nnn;
      OP_CALL: begin
        if (level == SLW'(STACK_DEPTH)) begin
          status = ST_OVERFLOW;
        end else begin
          push   = 1'b1;
          pc_new = nnn;
        end
      end
      OP_SE_IMM:  if (vx == kk) pc_new = pc_skip;
      OP_SNE_IMM: if (vx != kk) pc_new = pc_skip;
      OP_SE_REG:  if (vx == vy) pc_new = pc_skip;
      OP_SNE_REG: if (vx != vy) pc_new = pc_skip;
      OP_LD_IMM: begin
        rw   = 1'b1;
        rval = kk;
      end
      OP_ADD_IMM: begin
        rw   = 1'b1;
        rval = vx + kk;
      end
      OP_ALU: begin
        case (n)
          ALU_MOV: begin rw = 1'b1; rval = vy; end
          ALU_OR:  begin rw = 1'b1; rval = vx | vy; end
          ALU_AND: begin rw = 1'b1; rval = vx & vy; end
          ALU_XOR: begin rw = 1'b1; rval = vx ^ vy; end
          ALU_ADD: begin
            rw = 1'b1; fw = 1'b1;
            rval = sum[7:0];
            fval = {7'd0, sum[8]};
          end
          ALU_SUB: begin
            rw = 1'b1; fw = 1'b1;
            rval = vx - vy;
            fval = {7'd0, vx > vy};
          end
          ALU_SHR: begin
            rw = 1'b1; fw = 1'b1;
            rval = {1'b0, vx[7:1]};
            fval = {7'd0, vx[0]};
          end
          ALU_SUBN: begin
            rw = 1'b1; fw = 1'b1;
            rval = vy - vx;
            fval = {7'd0, vy > vx};
          end
          ALU_SHL: begin
            rw = 1'b1; fw = 1'b1;
            rval = {vx[6:0], 1'b0};
            fval = {7'd0, vx[7]};
          end
          default: ;
        endcase
      end
      OP_LD_I:  index_new = nnn;
      OP_JP_V0: pc_new = {4'd0, vy} + nnn;
      OP_RND: begin
        rw   = 1'b1;
        rval = rnd & kk;
      end
      OP_KEY: begin
        if (vx > KEY_MAX) begin
          status = ST_BAD_KEY;
        end else if (kk == KEY_DOWN_CODE) begin
          if (key_hit) pc_new = pc_skip;
        end else if (kk == KEY_UP_CODE) begin
          if (!key_hit) pc_new = pc_skip;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.status = status;
    res.pc     = (status == ST_OK) ? pc_new : pc;
    res.clr    = clr;
    res.rw     = rw;
    res.x      = x;
    res.rval   = rval;
    res.fw     = fw;
    res.index  = index_new;
    res.push   = push;
    res.pop    = pop;
    res.ret_pc = pc_adv;
    // a result aimed at VF replaces the flag
    if (status != ST_OK) begin
      res.vf = vf;
    end else if (rw && x == FLAG_REG) begin
      res.vf = rval;
    end else if (fw) begin
      res.vf = fval;
    end else begin
      res.vf = vf;
    end
  end

endmodule
`default_nettype wire

FILE: design/chip8_instruction_executor_top.sv
// An accepted input word passes through the input register and then the result register to result valid.
// Throughput: one instruction word per cycle while out_stall is low; register reads happen at accept and a
// write retiring on the same edge is forwarded, so dependent words run back to back.
// Reset (rst, synchronous): pc to 0x200, V0..VF and index to zero, stack empty,
// both pipeline registers empty. Stack contents are not cleared.
// Top level of the instruction executor.
`timescale 1ns / 1ps
`default_nettype none
module chip8_instruction_executor_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] instruction_word,
  input  wire logic [15:0] key_down_mask,
  input  wire logic [7:0]  random_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [1:0]  status,
  output logic      [11:0] next_pc,
  output logic             clear_screen,
  output logic             reg_written,
  output logic      [3:0]  reg_index,
  output logic      [7:0]  reg_value,
  output logic             flag_written,
  output logic      [7:0]  flag_value,
  output logic      [11:0] index_value
);
  import c8x_pkg::*;

  logic            in_full;
  logic [15:0]     in_word;
  logic [15:0]     in_keys;
  logic [7:0]      in_rnd;
  logic            accept;
  logic            advance;
  logic            commit;
  logic [11:0]     pc;
  logic [11:0]     index_reg;
  logic [7:0]      rd_a, rd_b, vf;
  logic [3:0]      rd_addr_b;
  logic [SLW-1:0]  level;
  logic [11:0]     tos;
  exec_res_t       res;

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign accept   = in_valid && !in_stall;
  assign commit   = advance && (res.status == ST_OK);

  // Bnnn needs V0 and no Vy, so port b reads V0 for it
  assign rd_addr_b = (instruction_word[15:12] == OP_JP_V0) ? 4'd0 : instruction_word[7:4];

  c8x_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr_a (instruction_word[11:8]),
    .rd_addr_b (rd_addr_b),
    .wr_en     (commit && res.rw),
    .wr_addr   (res.x),
    .wr_data   (res.rval),
    .vf_en     (commit),
    .vf_data   (res.vf),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b),
    .vf        (vf)
  );

  c8x_stack u_stack (
    .clk       (clk),
    .rst       (rst),
    .push      (commit && res.push),
    .pop       (commit && res.pop),
    .push_data (res.ret_pc),
    .level     (level),
    .tos       (tos)
  );

  c8x_exec u_exec (
    .word  (in_word),
    .keys  (in_keys),
    .rnd   (in_rnd),
    .rd_a  (rd_a),
    .rd_b  (rd_b),
    .vf    (vf),
    .pc    (pc),
    .index (index_reg),
    .level (level),
    .tos   (tos),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      in_word <= instruction_word;
      in_keys <= key_down_mask;
      in_rnd  <= random_byte;
    end
    if (advance) begin
      status       <= res.status;
      next_pc      <= res.pc;
      clear_screen <= res.clr;
      reg_written  <= res.rw;
      reg_index    <= res.rw ? res.x : 4'd0;
      reg_value    <= res.rw ? res.rval : 8'd0;
      flag_written <= res.fw;
      flag_value   <= res.vf;
      index_value  <= res.index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
      pc        <= PC_RESET;
      index_reg <= 12'd0;
    end else begin
      if (accept) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (commit) begin
        pc        <= res.pc;
        index_reg <= res.index;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/c8x_checker.sv
// Port-level checker for the executor and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module c8x_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  status,
  input wire logic [11:0] next_pc,
  input wire logic        clear_screen,
  input wire logic        reg_written,
  input wire logic [3:0]  reg_index,
  input wire logic [7:0]  reg_value,
  input wire logic        flag_written,
  input wire logic [7:0]  flag_value
);
  import c8x_pkg::*;

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid right after reset");

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(next_pc) && $stable(status)
      && $stable(reg_value))
    else $error("stalled result word changed");

  // an error status leaves registers and display alone
  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> !reg_written && !flag_written && !clear_screen)
    else $error("error word reports a write");

  // unwritten register fields read as zero
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reg_written |-> reg_index == 4'd0 && reg_value == 8'd0)
    else $error("register fields set without a write");

  // a flag write not overridden by a VF result is a single bit
  a_flag_bit: assert property (@(posedge clk) disable iff (rst)
    out_valid && flag_written && !(reg_written && reg_index == FLAG_REG)
      |-> flag_value[7:1] == 7'd0)
    else $error("flag value wider than one bit");

endmodule

bind chip8_instruction_executor_top c8x_checker u_c8x_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .next_pc      (next_pc),
  .clear_screen (clear_screen),
  .reg_written  (reg_written),
  .reg_index    (reg_index),
  .reg_value    (reg_value),
  .flag_written (flag_written),
  .flag_value   (flag_value)
);
`default_nettype wire

FILE: bench/chip8_instruction_executor_top_tb.sv
// Self-checking testbench for the instruction executor: predicted retires vs. DUT results.
`timescale 1ns / 1ps
module chip8_instruction_executor_top_tb;
  import c8x_pkg::*;

  localparam logic [3:0] OP_DRAW    = 4'hD;
  localparam logic [3:0] OP_MISC    = 4'hF;
  localparam logic [3:0] ALU_UNUSED = 4'hD;
  localparam int IDLE_LIMIT = 4000;
  localparam int WORD_TARGET = 550;

  typedef struct packed {
    status_t     status;
    logic [11:0] pc;
    logic        clr;
    logic        rw;
    logic [3:0]  ridx;
    logic [7:0]  rval;
    logic        fw;
    logic [7:0]  fval;
    logic [11:0] idx;
  } retire_t;

  typedef enum logic [1:0] {HOLD_NONE, HOLD_LIGHT, HOLD_HEAVY, HOLD_PERIODIC} hold_mode_t;

  // Architectural shadow of the executor plus the queue of retires still owed by the DUT.
  class retire_tracker;
    logic [11:0] pc;
    logic [7:0]  vreg [16];
    logic [11:0] index;
    logic [11:0] ret_stack [STACK_DEPTH];
    int          depth;
    retire_t     due [$];
    int          errors, results, skips_taken, stack_faults, key_faults;

    function new();
      pc = PC_RESET;
      foreach (vreg[i]) vreg[i] = 8'd0;
      index = 12'd0;
      depth = 0;
    endfunction

    function string fmt(retire_t r);
      return $sformatf("st=%0d pc=%h clr=%b rw=%b r=%h v=%h fw=%b vf=%h i=%h",
                       r.status, r.pc, r.clr, r.rw, r.ridx, r.rval, r.fw, r.fval, r.idx);
    endfunction

    function void predict_retire(logic [15:0] w, logic [15:0] keys, logic [7:0] rnd);
      retire_t     e;
      logic [3:0]  op, rx, ry, sub;
      logic [7:0]  kk, vx, vy, rv, fv;
      logic [11:0] nnn, npc;
      logic [8:0]  sum;
      logic        rw, fw, clr, skip;
      status_t     st;
      op = w[15:12]; rx = w[11:8]; ry = w[7:4]; sub = w[3:0];
      kk = w[7:0]; nnn = w[11:0];
      vx = vreg[rx]; vy = vreg[ry];
      npc = pc + 12'd2;
      st = ST_OK; rw = 1'b0; fw = 1'b0; clr = 1'b0; skip = 1'b0; rv = 8'd0; fv = 8'd0;
      case (op)
        OP_SYS: begin
          if (w == CLS_WORD) begin
            clr = 1'b1;
          end else if (w == RET_WORD) begin
            if (depth == 0) begin
              st = ST_UNDERFLOW;
            end else begin
              depth--;
              npc = ret_stack[depth];
            end
          end
        end
        OP_JP: npc = nnn;
        OP_CALL: begin
          if (depth >= STACK_DEPTH) begin
            st = ST_OVERFLOW;
          end else begin
            ret_stack[depth] = npc;
            depth++;
            npc = nnn;
          end
        end
        OP_SE_IMM:  skip = (vx == kk);
        OP_SNE_IMM: skip = (vx != kk);
        OP_SE_REG:  skip = (vx == vy);
        OP_SNE_REG: skip = (vx != vy);
        OP_LD_IMM: begin rw = 1'b1; rv = kk; end
        OP_ADD_IMM: begin rw = 1'b1; rv = vx + kk; end
        OP_ALU: begin
          rw = 1'b1;
          case (sub)
            ALU_MOV: rv = vy;
            ALU_OR:  rv = vx | vy;
            ALU_AND: rv = vx & vy;
            ALU_XOR: rv = vx ^ vy;
            ALU_ADD: begin
              sum = {1'b0, vx} + {1'b0, vy};
              rv = sum[7:0]; fv = {7'd0, sum[8]}; fw = 1'b1;
            end
            ALU_SUB:  begin rv = vx - vy; fv = {7'd0, vx > vy}; fw = 1'b1; end
            ALU_SHR:  begin rv = vx >> 1; fv = {7'd0, vx[0]}; fw = 1'b1; end
            ALU_SUBN: begin rv = vy - vx; fv = {7'd0, vy > vx}; fw = 1'b1; end
            ALU_SHL:  begin rv = vx << 1; fv = {7'd0, vx[7]}; fw = 1'b1; end
            default: rw = 1'b0;
          endcase
        end
        OP_LD_I: index = nnn;
        OP_JP_V0: npc = {4'd0, vreg[0]} + nnn;
        OP_RND: begin rw = 1'b1; rv = rnd & kk; end
        OP_KEY: begin
          if (vx > KEY_MAX) st = ST_BAD_KEY;
          else if (kk == KEY_DOWN_CODE) skip = keys[vx[3:0]];
          else if (kk == KEY_UP_CODE) skip = !keys[vx[3:0]];
        end
        default: ;
      endcase
      if (skip) npc = npc + 12'd2;
      if (st == ST_OK) begin
        pc = npc;
        // flag first: a result aimed at VF wins
        if (fw) vreg[FLAG_REG] = fv;
        if (rw) vreg[rx] = rv;
        if (skip) skips_taken++;
      end
      if (st == ST_OVERFLOW || st == ST_UNDERFLOW) stack_faults++;
      if (st == ST_BAD_KEY) key_faults++;
      e.status = st;
      e.pc = pc;
      e.clr = clr;
      e.rw = rw;
      e.ridx = rw ? rx : 4'd0;
      e.rval = rw ? rv : 8'd0;
      e.fw = fw;
      e.fval = vreg[FLAG_REG];
      e.idx = index;
      due.push_back(e);
    endfunction

    function void check_retire(retire_t got);
      retire_t want;
      string   bad;
      results++;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with nothing pending: %s", fmt(got));
        return;
      end
      want = due.pop_front();
      bad = "";
      if (got.status !== want.status) bad = {bad, " status"};
      if (got.pc !== want.pc) bad = {bad, " next_pc"};
      if (got.clr !== want.clr) bad = {bad, " clear_screen"};
      if (got.rw !== want.rw) bad = {bad, " reg_written"};
      if (got.ridx !== want.ridx) bad = {bad, " reg_index"};
      if (got.rval !== want.rval) bad = {bad, " reg_value"};
      if (got.fw !== want.fw) bad = {bad, " flag_written"};
      if (got.fval !== want.fval) bad = {bad, " flag_value"};
      if (got.idx !== want.idx) bad = {bad, " index_value"};
      if (bad != "") begin
        errors++;
        if (errors <= 10) begin
          $display("result %0d mismatch on%s", results, bad);
          $display("  expected %s", fmt(want));
          $display("  actual   %s", fmt(got));
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] instruction_word = 16'd0;
  logic [15:0] key_down_mask = 16'd0;
  logic [7:0]  random_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [11:0] next_pc;
  logic        clear_screen;
  logic        reg_written;
  logic [3:0]  reg_index;
  logic [7:0]  reg_value;
  logic        flag_written;
  logic [7:0]  flag_value;
  logic [11:0] index_value;

  chip8_instruction_executor_top dut (.*);

  retire_tracker sb = new();
  int words_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  int cycle_no = 0;
  hold_mode_t hold_mode = HOLD_NONE;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result checking, receiver stall pattern and watchdog.
  always @(posedge clk) begin
    retire_t got;
    cycle_no++;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got.status = status_t'(status);
        got.pc = next_pc;
        got.clr = clear_screen;
        got.rw = reg_written;
        got.ridx = reg_index;
        got.rval = reg_value;
        got.fw = flag_written;
        got.fval = flag_value;
        got.idx = index_value;
        sb.check_retire(got);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results pending",
                 idle_cycles, sb.due.size());
        $display("chip8_instruction_executor_top_tb: errors");
        $finish;
      end
    end
    if (hold_left == 0) begin
      hold_mode = hold_mode_t'($urandom_range(0, 3));
      hold_left = $urandom_range(20, 80);
    end else begin
      hold_left--;
    end
    case (hold_mode)
      HOLD_NONE:  out_stall <= 1'b0;
      HOLD_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      HOLD_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
      default:    out_stall <= ((cycle_no % 5) < 2);
    endcase
  end

  task automatic send_word(input logic [15:0] w);
    logic [15:0] keys;
    logic [7:0]  rnd;
    keys = 16'($urandom);
    rnd = 8'($urandom);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    instruction_word <= w;
    key_down_mask <= keys;
    random_byte <= rnd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.predict_retire(w, keys, rnd);
    words_sent++;
    burst_left--;
  endtask

  // Hold the sender off until every pending word has retired.
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] edge_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'h7F;
      3: return 8'h80;
      4: return 8'hFE;
      5: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int          kind, n, m;
    logic [3:0]  rx, ry, sub;
    logic [7:0]  kk;
    logic [11:0] nnn;
    bit          paused_mid;
    paused_mid = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed opening
    send_word(CLS_WORD);
    send_word(RET_WORD);                              // return with nothing on the stack
    send_word({OP_LD_IMM, 4'h0, 8'hFF});
    send_word({OP_ADD_IMM, 4'h0, 8'h01});             // wraps to zero
    send_word({OP_LD_IMM, 4'h1, 8'hFF});
    send_word({OP_ALU, 4'h1, 4'h1, ALU_ADD});         // carry out
    send_word({OP_ALU, 4'h0, 4'h1, ALU_SUB});         // borrow
    send_word({OP_ALU, 4'h1, 4'h0, ALU_SUBN});
    send_word({OP_ALU, FLAG_REG, 4'h0, ALU_SHL});     // result lands on VF
    send_word({OP_ALU, 4'h1, 4'h0, ALU_SHL});
    send_word({OP_ALU, 4'h1, 4'h0, ALU_SHR});
    send_word({OP_ALU, 4'h1, 4'h2, ALU_XOR});
    send_word({OP_ALU, 4'h1, 4'h2, ALU_UNUSED});
    send_word({OP_JP, 12'hFFE});
    send_word({OP_CALL, 12'hABC});                    // pushes a wrapped pc
    send_word(RET_WORD);
    send_word({OP_SE_IMM, 4'h0, 8'h00});
    send_word({OP_SE_REG, 4'h0, 4'h1, 4'hF});         // low nibble ignored
    send_word({OP_LD_I, 12'hFFF});
    send_word({OP_JP_V0, 12'hFFF});
    send_word({OP_RND, 4'h3, 8'hA5});
    send_word({OP_LD_IMM, 4'hE, KEY_MAX});
    send_word({OP_KEY, 4'hE, KEY_DOWN_CODE});
    send_word({OP_LD_IMM, 4'hE, 8'h10});
    send_word({OP_KEY, 4'hE, KEY_UP_CODE});           // key out of range
    send_word({OP_DRAW, 12'hFFF});
    send_word({OP_MISC, 12'hFFF});
    drain_results();

    // fill the stack past its end, then empty it past its start
    repeat (STACK_DEPTH + 1) begin
      nnn = 12'($urandom);
      send_word({OP_CALL, nnn});
    end
    repeat (STACK_DEPTH + 1) send_word(RET_WORD);

    while (words_sent < WORD_TARGET) begin
      if (!paused_mid && words_sent > WORD_TARGET / 2) begin
        drain_results();
        paused_mid = 1'b1;
      end
      kind = $urandom_range(0, 11);
      rx = 4'($urandom);
      ry = 4'($urandom);
      kk = 8'($urandom);
      nnn = 12'($urandom);
      case (kind)
        0: send_word(16'($urandom));
        1: begin
          // nested subroutine calls, mostly balanced
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, STACK_DEPTH + 2)
                                          : $urandom_range(1, 4);
          repeat (n) begin
            nnn = 12'($urandom);
            send_word({OP_CALL, nnn});
          end
          if ($urandom_range(0, 1)) send_word({OP_ALU, rx, ry, ALU_ADD});
          m = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n + 1) : n;
          repeat (m) send_word(RET_WORD);
        end
        2: begin
          kk = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(16, 255)
                                              : $urandom_range(0, 15));
          send_word({OP_LD_IMM, rx, kk});
          case ($urandom_range(0, 4))
            0, 1: kk = KEY_DOWN_CODE;
            2, 3: kk = KEY_UP_CODE;
            default: kk = 8'($urandom);
          endcase
          send_word({OP_KEY, rx, kk});
        end
        3, 4, 10, 11: begin
          if ($urandom_range(0, 1)) begin
            send_word({OP_LD_IMM, rx, edge_byte()});
            send_word({OP_LD_IMM, ry, edge_byte()});
          end
          n = $urandom_range(0, 10);
          if (n < 8) sub = 4'(n);
          else if (n == 8) sub = ALU_SHL;
          else sub = 4'($urandom);
          send_word({OP_ALU, rx, ry, sub});
        end
        5: begin
          if ($urandom_range(0, 1)) kk = sb.vreg[rx];
          send_word({$urandom_range(0, 1) ? OP_SE_IMM : OP_SNE_IMM, rx, kk});
        end
        6: begin
          if ($urandom_range(0, 1)) send_word({OP_LD_IMM, rx, sb.vreg[ry]});
          sub = 4'($urandom);
          send_word({$urandom_range(0, 1) ? OP_SE_REG : OP_SNE_REG, rx, ry, sub});
        end
        7: begin
          case ($urandom_range(0, 2))
            0: send_word({OP_JP, nnn});
            1: send_word({OP_LD_I, nnn});
            default: send_word({OP_JP_V0, nnn});
          endcase
        end
        8: begin
          case ($urandom_range(0, 2))
            0: send_word({OP_RND, rx, kk});
            1: send_word({OP_LD_IMM, rx, edge_byte()});
            default: send_word({OP_ADD_IMM, rx, edge_byte()});
          endcase
        end
        default: begin
          case ($urandom_range(0, 3))
            0: send_word({OP_DRAW, nnn});
            1: send_word({OP_MISC, nnn});
            2: send_word({OP_SYS, nnn});
            default: send_word($urandom_range(0, 1) ? CLS_WORD : RET_WORD);
          endcase
        end
      endcase
    end

    drain_results();
    repeat (10) @(posedge clk);
    $display("%0d words retired and checked (%0d results seen)", words_sent, sb.results);
    $display("%0d skips taken, %0d stack faults, %0d invalid keys, %0d errors",
             sb.skips_taken, sb.stack_faults, sb.key_faults, sb.errors);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("chip8_instruction_executor_top_tb: clean");
    end else begin
      $display("chip8_instruction_executor_top_tb: errors");
    end
    $finish;
  end

endmodule
